// ----- hw/rtl/bvs_pkg.sv -----
// ----------------------------------------------------------------------------
// bvs_pkg
// Types and codes shared by the bounded vector store.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned KindW  = 3;
  localparam int unsigned LiveW  = 7;
  localparam int unsigned GroupN = 32;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [PosW-1:0]         pos_t;
  typedef logic [LiveW-1:0]        live_t;

  typedef enum logic [KindW-1:0] {
    REQ_APPEND = 3'd0,
    REQ_DROP   = 3'd1,
    REQ_WRITE  = 3'd2,
    REQ_READ   = 3'd3,
    REQ_REMOVE = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADIDX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GATHER
  } state_e;

  typedef struct packed {
    logic [KindW-1:0] req_type;
    pos_t             position;
    word_t            word_in;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    word_t      word_out;
    live_t      live_count;
    logic       empty_flag;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic rd_sel;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/bvs_chan_if.sv -----
// ----------------------------------------------------------------------------
// bvs_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface bvs_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ----- hw/rtl/bvs_cell.sv -----
// ----------------------------------------------------------------------------
// bvs_cell
// One list entry: load a new word, take the neighbor's word, or hold.
// ----------------------------------------------------------------------------
module bvs_cell (
  input  logic               clk_i,
  input  bvs_pkg::cell_ctl_t ctl_i,
  input  bvs_pkg::word_t     wdata_i,
  input  bvs_pkg::word_t     next_i,
  output bvs_pkg::word_t     entry_o,
  output bvs_pkg::word_t     rd_o
);

  bvs_pkg::word_t entry_q;
  bvs_pkg::word_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load) begin
      entry_d = wdata_i;
    end else if (ctl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = ctl_i.rd_sel ? entry_q : '0;

endmodule

// ----- hw/rtl/bvs_gather.sv -----
// ----------------------------------------------------------------------------
// bvs_gather
// Two-level read tree: register the OR of each group of cells, then merge.
// ----------------------------------------------------------------------------
module bvs_gather #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  bvs_pkg::word_t lane_i [CAPACITY],
  output bvs_pkg::word_t word_o
);

  localparam int unsigned NumGrp = (CAPACITY + bvs_pkg::GroupN - 1) / bvs_pkg::GroupN;

  bvs_pkg::word_t grp_q [NumGrp];
  bvs_pkg::word_t grp_d [NumGrp];

  for (genvar g = 0; g < NumGrp; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int unsigned j = 0; j < bvs_pkg::GroupN; j++) begin
        if (g * bvs_pkg::GroupN + j < CAPACITY) begin
          grp_d[g] = grp_d[g] | lane_i[g * bvs_pkg::GroupN + j];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  always_comb begin
    word_o = '0;
    for (int unsigned g = 0; g < NumGrp; g++) begin
      word_o = word_o | grp_q[g];
    end
  end

endmodule

// ----- hw/rtl/bounded_vector_store.sv -----
// ----------------------------------------------------------------------------
// bounded_vector_store
// Fixed-capacity ordered list of signed words with compacting remove.
// ----------------------------------------------------------------------------
// Each item passes through three steps: it is accepted into the request
// register, then every cell updates at once (write, append, or shift down
// past the removal point) while the read tree registers its group ORs, and
// last the groups are merged into the output register, where the result is
// valid. The two-level read tree over the row of cells sets these steps.
// A new item is accepted once the previous one has reached the output
// register, even while that result still waits to be taken; the new item then
// holds in the merge step until the output register frees. Entries come up
// undefined after reset and are only read after they were written, so no
// clearing pass runs.
// ----------------------------------------------------------------------------
module bounded_vector_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bvs_chan_if.sink        req_i,
  bvs_chan_if.source      rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > bvs_pkg::PosW) ? CntW : bvs_pkg::PosW;

  bvs_pkg::state_e state_q, state_d;
  bvs_pkg::req_t   req_q;
  logic [CntW-1:0] count_q, count_d;

  logic            req_ready;
  logic            exec_en;
  logic            emit;

  bvs_pkg::rsp_t   res_q, res_d;
  logic            rd_q, rd_d;
  logic            bad_q, bad_d;
  bvs_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic [CmpW-1:0] pos_x;
  logic [CmpW-1:0] cnt_x;
  logic            full;
  logic            do_app;
  logic            app_ok;
  logic            wr_ok;
  logic            in_range;
  logic            rm_ok;
  logic            rd_ok;
  logic [bvs_pkg::KindW-1:0] kind;

  bvs_pkg::cell_ctl_t ctl [CAPACITY];
  bvs_pkg::word_t     entry [CAPACITY];
  bvs_pkg::word_t     lane [CAPACITY];
  bvs_pkg::word_t     gather_word;

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bvs_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          state_d = bvs_pkg::ST_EXEC;
        end
      end
      bvs_pkg::ST_EXEC: begin
        state_d = bvs_pkg::ST_GATHER;
      end
      bvs_pkg::ST_GATHER: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = bvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bvs_pkg::ST_IDLE;
      end
    endcase
  end

  // FSM outputs
  always_comb begin
    req_ready = 1'b0;
    exec_en   = 1'b0;
    emit      = 1'b0;
    case (state_q)
      bvs_pkg::ST_IDLE: begin
        req_ready = 1'b1;
      end
      bvs_pkg::ST_EXEC: begin
        exec_en = 1'b1;
      end
      bvs_pkg::ST_GATHER: begin
        emit = !rsp_valid_q || rsp_o.ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign req_i.ready = req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bvs_pkg::ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    rsp_d = res_q;
    if (rd_q) begin
      rsp_d.word_out = bad_q ? '1 : gather_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready && req_i.valid) begin
      req_q <= req_i.payload;
    end
    if (exec_en) begin
      res_q <= res_d;
      rd_q  <= rd_d;
      bad_q <= bad_d;
    end
    if (emit) begin
      rsp_q <= rsp_d;
    end
  end

  // Request decode against the live count
  assign kind     = req_q.req_type;
  assign pos_x    = CmpW'(req_q.position);
  assign cnt_x    = CmpW'(count_q);
  assign full     = (count_q == CntW'(CAPACITY));
  assign in_range = (pos_x < cnt_x);
  assign do_app   = (kind == bvs_pkg::REQ_APPEND) ||
                    ((kind == bvs_pkg::REQ_WRITE) && (pos_x == cnt_x));
  assign app_ok   = do_app && !full;
  assign wr_ok    = (kind == bvs_pkg::REQ_WRITE) && in_range;
  assign rm_ok    = (kind == bvs_pkg::REQ_REMOVE) && in_range;
  assign rd_ok    = (kind == bvs_pkg::REQ_READ) && in_range;

  always_comb begin
    logic [1:0] stat;
    stat    = bvs_pkg::STAT_OK;
    count_d = count_q;
    if (do_app && full) begin
      stat = bvs_pkg::STAT_FULL;
    end
    if ((kind == bvs_pkg::REQ_DROP) && (count_q == '0)) begin
      stat = bvs_pkg::STAT_EMPTY;
    end
    if (((kind == bvs_pkg::REQ_WRITE) && (pos_x > cnt_x)) ||
        (((kind == bvs_pkg::REQ_READ) || (kind == bvs_pkg::REQ_REMOVE)) && !in_range)) begin
      stat = bvs_pkg::STAT_BADIDX;
    end
    if (exec_en) begin
      if (app_ok) begin
        count_d = count_q + CntW'(1);
      end else if (((kind == bvs_pkg::REQ_DROP) && (count_q != '0)) || rm_ok) begin
        count_d = count_q - CntW'(1);
      end
    end
    res_d.status     = stat;
    res_d.word_out   = '0;
    res_d.live_count = bvs_pkg::live_t'(count_d);
    res_d.empty_flag = (count_d == '0);
    rd_d             = (kind == bvs_pkg::REQ_READ);
    bad_d            = !in_range;
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ctl[i].load   = exec_en && ((app_ok && (cnt_x == CmpW'(i))) ||
                                       (wr_ok && (pos_x == CmpW'(i))));
    assign ctl[i].shift  = exec_en && rm_ok && (CmpW'(i) >= pos_x) &&
                           (CmpW'(i + 1) < cnt_x);
    assign ctl[i].rd_sel = rd_ok && (pos_x == CmpW'(i));

    if (i + 1 < CAPACITY) begin : g_mid
      bvs_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl[i]),
        .wdata_i (req_q.word_in),
        .next_i  (entry[i+1]),
        .entry_o (entry[i]),
        .rd_o    (lane[i])
      );
    end else begin : g_last
      bvs_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl[i]),
        .wdata_i (req_q.word_in),
        .next_i  (entry[i]),
        .entry_o (entry[i]),
        .rd_o    (lane[i])
      );
    end
  end

  bvs_gather #(
    .CAPACITY (CAPACITY)
  ) u_gather (
    .clk_i  (clk_i),
    .en_i   (exec_en),
    .lane_i (lane),
    .word_o (gather_word)
  );

  // Output register
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (emit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule
